// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define AST_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define AST_IMPL(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/atu_pkg.sv =====
// ----------------------------------------------------------------------------
// atu_pkg
// Types, constants and helper functions of the 2D affine transform unit.
// ----------------------------------------------------------------------------
package atu_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  // Command codes carried on the input tuser.
  localparam logic [2:0] MODE_IDENT = 3'd0;
  localparam logic [2:0] MODE_TRANS = 3'd1;
  localparam logic [2:0] MODE_SCALE = 3'd2;
  localparam logic [2:0] MODE_ROT   = 3'd3;
  localparam logic [2:0] MODE_POINT = 3'd4;

  // Accumulator wide enough for two full products plus a rounding term.
  localparam int ACC_W = 66;

  // Angle reduction: one conditional subtract of 2*pi << k per step.
  localparam int RED_STEPS = 30 - FRAC_BITS;
  localparam int RK_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int CI_W      = $clog2(CORDIC_STEPS);

  localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
  localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
  localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032875;

  localparam logic signed [31:0] ONE_FIX = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    CMD_IDENT,
    CMD_TRANS,
    CMD_SCALE,
    CMD_ROT,
    CMD_POINT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FOLD,
    ST_CORDIC,
    ST_TRIG,
    ST_MUL,
    ST_ACC,
    ST_WRITE,
    ST_COMMIT,
    ST_OUT
  } eng_state_t;

  // Saturate a wide signed value to 32 bits and flag the clamp.
  function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v > ACC_W'(33'sh0_7FFF_FFFF)) begin
      r.ovf = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < -ACC_W'(33'sh0_8000_0000)) begin
      r.ovf = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      default: a = 32'h0;
    endcase
    return $signed({2'b00, a});
  endfunction

endpackage

// ===== rtl/core/atu_front.sv =====
// ----------------------------------------------------------------------------
// atu_front
// Input stage: takes command beats, drops unused modes and decodes the rest.
// ----------------------------------------------------------------------------
module atu_front import atu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // first_value[31:0], second_value[63:32]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic      fvalid;
  cmd_t      fcmd;
  cmd_kind_t kind;
  logic      take;

  // Hand the held command to the queue whenever it has room.
  assign push     = fvalid && !q_full;
  assign push_cmd = fcmd;
  assign s_tready = !fvalid || !q_full;
  assign take     = s_tvalid && s_tready;

  // Map the mode code onto a command kind.
  always_comb begin
    case (s_tuser)
      MODE_IDENT: kind = CMD_IDENT;
      MODE_TRANS: kind = CMD_TRANS;
      MODE_SCALE: kind = CMD_SCALE;
      MODE_ROT:   kind = CMD_ROT;
      MODE_POINT: kind = CMD_POINT;
      default:    kind = CMD_IDENT;
    endcase
  end

  // Holding register; unused modes are accepted and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (take && (s_tuser inside {[MODE_IDENT:MODE_POINT]})) begin
      fvalid <= 1'b1;
    end else if (push) begin
      fvalid <= 1'b0;
    end
    if (take) begin
      fcmd.kind <= kind;
      fcmd.v1   <= $signed(s_tdata[31:0]);
      fcmd.v2   <= $signed(s_tdata[63:32]);
    end
  end

endmodule

// ===== rtl/core/atu_queue.sv =====
// ----------------------------------------------------------------------------
// atu_queue
// Two-entry command queue between the input stage and the engine.
// ----------------------------------------------------------------------------
module atu_queue import atu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/atu_engine.sv =====
// ----------------------------------------------------------------------------
// atu_engine
// Executes commands: matrix updates, CORDIC sine and cosine, point transform,
// all products through one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module atu_engine import atu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_x[31:0], out_y[63:32]
  output logic        m_tuser    // overflow
);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [33:0]      TRND = 34'sd1 <<< (29 - FRAC_BITS);

  eng_state_t state, state_next;

  logic signed [31:0] mat  [6];
  logic signed [31:0] nmat [6];
  logic               sticky;
  cmd_t               cur;
  logic [2:0]         o_idx;
  logic               t_idx;
  logic signed [ACC_W-1:0] acc;
  logic signed [63:0] prod;
  logic               ovf;
  logic [63:0]        red_mag;
  logic               red_neg;
  logic [RK_W-1:0]    red_k;
  logic signed [33:0] cx, cy, cz;
  logic               fold_neg;
  logic [CI_W-1:0]    it;
  logic signed [31:0] cs, sn;
  logic signed [31:0] pt_x, pt_y;
  logic signed [31:0] ox, oy;
  logic               oovf, ovalid;

  logic signed [31:0] opa, opb, addend;
  logic               last_term, last_out;
  logic [2:0]         base;
  sat_t               res, tr_e, tr_f;
  logic [63:0]        red_sub;
  logic signed [63:0] fold_r;
  logic               fold_flag;
  logic signed [33:0] dx, dy, cang, xr, yr;
  logic [63:0]        v1_ext;

  assign m_tvalid = ovalid;
  assign m_tdata  = {oy, ox};
  assign m_tuser  = oovf;

  // Operand selection for the shared multiplier.
  always_comb begin
    base      = {o_idx[2:1], 1'b0};
    opa       = '0;
    opb       = '0;
    addend    = '0;
    last_term = 1'b1;
    last_out  = (o_idx == 3'd5);
    case (cur.kind)
      CMD_SCALE: begin
        opa = mat[o_idx];
        opb = o_idx[0] ? cur.v2 : cur.v1;
      end
      CMD_ROT: begin
        last_term = t_idx;
        opa = t_idx ? mat[base + 3'd1] : mat[base];
        if (!o_idx[0]) begin
          opb = t_idx ? -sn : cs;
        end else begin
          opb = t_idx ? cs : sn;
        end
      end
      CMD_POINT: begin
        last_term = t_idx;
        last_out  = o_idx[0];
        opa       = t_idx ? cur.v2 : cur.v1;
        opb       = mat[{1'b0, t_idx, o_idx[0]}];
        addend    = mat[{2'b10, o_idx[0]}];
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  // Rounding, addend and saturation of a finished sum of products.
  assign res = sat32((acc >>> FRAC_BITS) + ACC_W'(addend));

  // Translation adds straight from the queue head.
  assign tr_e = sat32(ACC_W'(mat[4]) + ACC_W'(cmd.v1));
  assign tr_f = sat32(ACC_W'(mat[5]) + ACC_W'(cmd.v2));

  // Angle reduction, fold into [-pi/2, pi/2] and CORDIC step terms.
  always_comb begin
    v1_ext    = 64'($signed(cmd.v1)) <<< (30 - FRAC_BITS);
    red_sub   = 64'(Q30_TWO_PI) << red_k;
    fold_r    = red_neg ? -$signed(red_mag) : $signed(red_mag);
    fold_flag = 1'b0;
    if (fold_r > Q30_PI) begin
      fold_r = fold_r - Q30_TWO_PI;
    end
    if (fold_r < -Q30_PI) begin
      fold_r = fold_r + Q30_TWO_PI;
    end
    if (fold_r > Q30_HALF_PI) begin
      fold_r    = fold_r - Q30_PI;
      fold_flag = 1'b1;
    end else if (fold_r < -Q30_HALF_PI) begin
      fold_r    = fold_r + Q30_PI;
      fold_flag = 1'b1;
    end
    dx   = cy >>> it;
    dy   = cx >>> it;
    cang = atan_q30(5'(it));
    xr   = (cx + TRND) >>> (30 - FRAC_BITS);
    yr   = (cy + TRND) >>> (30 - FRAC_BITS);
  end

  // Next state and queue pop.
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_SCALE, CMD_POINT: state_next = ST_MUL;
            CMD_ROT:              state_next = ST_REDUCE;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_REDUCE: begin
        if (red_k == '0) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD:   state_next = ST_CORDIC;
      ST_CORDIC: begin
        if (it == CI_W'(CORDIC_STEPS - 1)) begin
          state_next = ST_TRIG;
        end
      end
      ST_TRIG: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = last_term ? ST_WRITE : ST_MUL;
      ST_WRITE: begin
        if (!last_out) begin
          state_next = ST_MUL;
        end else if (cur.kind == CMD_POINT) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: state_next = ST_IDLE;
      ST_OUT: begin
        if (!ovalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register, matrix, sticky flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ovalid <= 1'b0;
      sticky <= 1'b0;
      mat[0] <= ONE_FIX;
      mat[1] <= '0;
      mat[2] <= '0;
      mat[3] <= ONE_FIX;
      mat[4] <= '0;
      mat[5] <= '0;
    end else begin
      state <= state_next;
      // The output beat is raised once the register is free and drops when taken.
      if (state == ST_OUT && (!ovalid || m_tready)) begin
        ovalid <= 1'b1;
      end else if (m_tready) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd.kind == CMD_IDENT) begin
            mat[0] <= ONE_FIX;
            mat[1] <= '0;
            mat[2] <= '0;
            mat[3] <= ONE_FIX;
            mat[4] <= '0;
            mat[5] <= '0;
            sticky <= 1'b0;
          end else if (cmd_valid && cmd.kind == CMD_TRANS) begin
            mat[4] <= tr_e.val;
            mat[5] <= tr_f.val;
            sticky <= sticky | tr_e.ovf | tr_f.ovf;
          end
        end
        ST_COMMIT: begin
          for (int i = 0; i < 6; i++) begin
            mat[i] <= nmat[i];
          end
          sticky <= sticky | ovf;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur     <= cmd;
        o_idx   <= '0;
        t_idx   <= 1'b0;
        acc     <= HALF;
        ovf     <= 1'b0;
        red_neg <= cmd.v1[31];
        red_mag <= cmd.v1[31] ? -v1_ext : v1_ext;
        red_k   <= RK_W'(RED_STEPS - 1);
      end
      ST_REDUCE: begin
        if (red_mag >= red_sub) begin
          red_mag <= red_mag - red_sub;
        end
        red_k <= red_k - RK_W'(1);
      end
      ST_FOLD: begin
        cz       <= 34'(fold_r);
        fold_neg <= fold_flag;
        cx       <= Q30_GAIN;
        cy       <= '0;
        it       <= '0;
      end
      ST_CORDIC: begin
        if (!cz[33]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - cang;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + cang;
        end
        it <= it + CI_W'(1);
      end
      ST_TRIG: begin
        cs <= 32'(fold_neg ? -xr : xr);
        sn <= 32'(fold_neg ? -yr : yr);
      end
      ST_MUL: begin
        prod <= opa * opb;
      end
      ST_ACC: begin
        acc   <= acc + ACC_W'(prod);
        t_idx <= !t_idx;
      end
      ST_WRITE: begin
        ovf   <= ovf | res.ovf;
        t_idx <= 1'b0;
        acc   <= HALF;
        o_idx <= o_idx + 3'd1;
        if (cur.kind == CMD_POINT) begin
          if (!o_idx[0]) begin
            pt_x <= res.val;
          end else begin
            pt_y <= res.val;
          end
        end else begin
          nmat[o_idx] <= res.val;
        end
      end
      ST_OUT: begin
        // Load the output register only once the previous beat has left.
        if (!ovalid || m_tready) begin
          ox   <= pt_x;
          oy   <= pt_y;
          oovf <= ovf | sticky;
        end
      end
      default: begin
        it <= it;
      end
    endcase
  end

endmodule

// ===== rtl/core/affine_2d_transform_unit.sv =====
// ----------------------------------------------------------------------------
// affine_2d_transform_unit
// 2D affine transform in Q16.16: builds the matrix from commands and
// transforms points, with saturation and an overflow flag.
//
//   channel | dir | tdata                          | tuser
//   s_*     | in  | first_value, second_value      | mode
//   m_*     | out | out_x, out_y                   | overflow
//
// Identity and translate are applied straight from the queue head; scale,
// rotate (14 angle reduction steps, 16 CORDIC steps, then 6 entries) and
// point use the shared 32x32 multiplier.
// Reset is synchronous and loads the identity matrix.
// A two-entry queue lets the input side keep taking beats while the
// engine works or the output beat stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_2d_transform_unit import atu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // first_value[31:0], second_value[63:32]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_x[31:0], out_y[63:32]
  output logic        m_tuser    // overflow
);

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;
  q_status_t qs;

  // Input stage.
  atu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (qs.full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  atu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (qs)
  );

  // Execution engine.
  atu_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head),
    .cmd_valid (!qs.empty),
    .cmd_pop   (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // The queue is never written when full nor read when empty.
  `AST_IMPL(a_no_push_full, push, !qs.full)
  `AST_IMPL(a_no_pop_empty, pop, !qs.empty)
  // A push into an empty queue leaves it non-empty next cycle.
  `AST_CLK(a_push_fills, (push && qs.empty && !pop) |=> !qs.empty)

endmodule
